### rtl/csmab_pkg.sv
// Shared types, codes and reset values for the CSMA/CA backoff station.
`timescale 1ns / 1ps

package csmab_pkg;

	localparam int unsigned EXP_W     = 4;
	localparam int unsigned IFS_W     = 4;
	localparam int unsigned BACKOFF_W = 15;
	localparam int unsigned WINDOW_W  = 16;
	localparam int unsigned RAND_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 4;

	typedef enum logic [1:0] {
		MODE_TICK      = 2'd0,
		MODE_SUCCESS   = 2'd1,
		MODE_COLLISION = 2'd2,
		MODE_NONE      = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IFS_TICKS  = 2'd0,
		REG_MIN_WINDOW = 2'd1,
		REG_MAX_WINDOW = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_index_t;

	localparam logic [IFS_W-1:0] IFS_TICKS_RST  = 4'd3;
	localparam logic [EXP_W-1:0] MIN_WINDOW_RST = 4'd3;
	localparam logic [EXP_W-1:0] MAX_WINDOW_RST = 4'd12;

	// Contention window in slots for a given log2 size.
	function automatic logic [WINDOW_W-1:0] window_of(input logic [EXP_W-1:0] exp);
		window_of = WINDOW_W'(1) << exp;
	endfunction

	// Backoff draw: the random bits masked to the window, limited to the counter width.
	function automatic logic [BACKOFF_W-1:0] draw_of(input logic [EXP_W-1:0] exp,
		input logic [RAND_W-1:0] rnd);
		logic [WINDOW_W-1:0] mask;
		mask    = window_of(exp) - WINDOW_W'(1);
		draw_of = rnd[BACKOFF_W-1:0] & mask[BACKOFF_W-1:0];
	endfunction

endpackage

### rtl/csma_ca_backoff_station.sv
// Top level of the CSMA/CA station with binary exponential backoff.
// Each request on the input channel carries one event: a slot tick, a
// transmission success, a collision or none, with the channel state, a packet
// offer and random bits for the backoff draw. For each request the block
// returns one result on the output channel: the transmit start flag, the
// station state, the contention window, the backoff slots left and the
// pending packet flag, all as they stand after the event.
// A request is taken into an input register; its state update is then done
// and the result is written into the output register. One request is taken
// in every cycle while results are drained. The output register stalls when
// it holds a result and out_ready is low; the input register still takes
// one more request, so in_ready falls only when both hold a request.
// The three configuration registers are written with cfg_we, one index and
// data word a cycle, and should only change while no request is in flight.
// Reset clears both stages, puts the station in idle with no packet and sets
// the registers and the window to their defaults.
`timescale 1ns / 1ps

module csma_ca_backoff_station (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          mode,
	input  logic                                channel_idle,
	input  logic                                packet_offer,
	input  logic [csmab_pkg::RAND_W-1:0]        random_draw,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                transmit_start,
	output logic [1:0]                          station_state,
	output logic [csmab_pkg::WINDOW_W-1:0]      window_size,
	output logic [csmab_pkg::BACKOFF_W-1:0]     backoff_left,
	output logic                                packet_waiting,
	input  logic                                cfg_we,
	input  logic [csmab_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csmab_pkg::CFG_W-1:0]         cfg_data
);

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_IFS     = 2'd1,
		PH_BACKOFF = 2'd2,
		PH_TX      = 2'd3
	} phase_t;

	logic                               valid_s1;
	csmab_pkg::mode_t                   mode_s1;
	logic                               idle_s1;
	logic                               offer_s1;
	logic [csmab_pkg::RAND_W-1:0]       rnd_s1;

	logic [csmab_pkg::IFS_W-1:0]        ifs_ticks_q;
	logic [csmab_pkg::EXP_W-1:0]        min_exp_q;
	logic [csmab_pkg::EXP_W-1:0]        max_exp_q;

	phase_t                             phase_q;
	logic [csmab_pkg::IFS_W-1:0]        ifs_count_q;
	logic [csmab_pkg::BACKOFF_W-1:0]    backoff_q;
	logic [csmab_pkg::EXP_W-1:0]        window_exp_q;
	logic                               pending_q;

	logic                               out_valid_q;
	logic                               start_q;

	phase_t                             phase_d;
	logic [csmab_pkg::IFS_W-1:0]        ifs_count_d;
	logic [csmab_pkg::BACKOFF_W-1:0]    backoff_d;
	logic [csmab_pkg::EXP_W-1:0]        window_exp_d;
	logic                               pending_d;
	logic                               start_d;

	logic                               advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= csmab_pkg::mode_t'(mode);
			idle_s1  <= channel_idle;
			offer_s1 <= packet_offer;
			rnd_s1   <= random_draw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ifs_ticks_q <= csmab_pkg::IFS_TICKS_RST;
			min_exp_q   <= csmab_pkg::MIN_WINDOW_RST;
			max_exp_q   <= csmab_pkg::MAX_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (csmab_pkg::reg_index_t'(cfg_index))
				csmab_pkg::REG_IFS_TICKS:  ifs_ticks_q <= cfg_data;
				csmab_pkg::REG_MIN_WINDOW: min_exp_q   <= cfg_data;
				csmab_pkg::REG_MAX_WINDOW: max_exp_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d      = phase_q;
		ifs_count_d  = ifs_count_q;
		backoff_d    = backoff_q;
		window_exp_d = window_exp_q;
		pending_d    = pending_q;
		start_d      = 1'b0;
		case (mode_s1)
			csmab_pkg::MODE_TICK: begin
				pending_d = pending_q | offer_s1;
				if (pending_d) begin
					unique case (phase_q)
						PH_IDLE: begin
							phase_d     = PH_IFS;
							ifs_count_d = ifs_ticks_q;
						end
						PH_IFS: begin
							if (!idle_s1) begin
								ifs_count_d = ifs_ticks_q;
							end else if (ifs_count_q > csmab_pkg::IFS_W'(1)) begin
								ifs_count_d = ifs_count_q - csmab_pkg::IFS_W'(1);
							end else begin
								ifs_count_d = '0;
								backoff_d   = csmab_pkg::draw_of(window_exp_q, rnd_s1);
								phase_d     = PH_BACKOFF;
							end
						end
						PH_BACKOFF: begin
							if (idle_s1) begin
								if (backoff_q > csmab_pkg::BACKOFF_W'(1)) begin
									backoff_d = backoff_q - csmab_pkg::BACKOFF_W'(1);
								end else begin
									backoff_d = '0;
									phase_d   = PH_TX;
									start_d   = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			csmab_pkg::MODE_SUCCESS: begin
				if (phase_q == PH_TX) begin
					window_exp_d = min_exp_q;
					pending_d    = 1'b0;
					phase_d      = PH_IDLE;
				end
			end
			csmab_pkg::MODE_COLLISION: begin
				if (phase_q == PH_TX) begin
					if (window_exp_q < max_exp_q) begin
						window_exp_d = window_exp_q + csmab_pkg::EXP_W'(1);
					end else begin
						window_exp_d = max_exp_q;
					end
					backoff_d = csmab_pkg::draw_of(window_exp_d, rnd_s1);
					phase_d   = PH_BACKOFF;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			ifs_count_q  <= '0;
			backoff_q    <= '0;
			window_exp_q <= csmab_pkg::MIN_WINDOW_RST;
			pending_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			start_q      <= 1'b0;
		end else begin
			if (advance) begin
				phase_q      <= phase_d;
				ifs_count_q  <= ifs_count_d;
				backoff_q    <= backoff_d;
				window_exp_q <= window_exp_d;
				pending_q    <= pending_d;
				start_q      <= start_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign transmit_start = start_q;
	assign station_state  = phase_q;
	assign window_size    = csmab_pkg::window_of(window_exp_q);
	assign backoff_left   = backoff_q;
	assign packet_waiting = pending_q;

`ifndef SYNTH
	a_start_in_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transmit_start |-> station_state == PH_TX)
		else $error("transmit start reported outside the transmitting state");

	a_no_packet_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_waiting |-> station_state == PH_IDLE)
		else $error("station active without a pending packet");

	a_window_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(window_size))
		else $error("contention window is not a power of two");

	a_backoff_only_in_backoff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && station_state != PH_BACKOFF |-> backoff_left == '0)
		else $error("backoff slots left outside the backoff state");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |=> valid_s1 && out_valid)
		else $error("input stage lost a request while the output stalled");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the CSMA/CA backoff station: directed script, then random events.
`timescale 1ns / 1ps

module tb;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 4;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_IFS     = 2'd1,
		ST_BACKOFF = 2'd2,
		ST_TX      = 2'd3
	} station_phase_t;

	typedef struct packed {
		csmab_pkg::mode_t             mode;
		logic                         idle;
		logic                         offer;
		logic [csmab_pkg::RAND_W-1:0] rnd;
	} station_req_t;

	typedef struct packed {
		logic                            start;
		logic [1:0]                      state;
		logic [csmab_pkg::WINDOW_W-1:0]  window;
		logic [csmab_pkg::BACKOFF_W-1:0] backoff;
		logic                            waiting;
	} station_result_t;

	typedef struct packed {
		station_req_t    req;
		logic            typed;
		station_result_t res;
	} script_row_t;

	typedef struct {
		logic [csmab_pkg::CFG_W-1:0] ifs;
		logic [csmab_pkg::CFG_W-1:0] min_exp;
		logic [csmab_pkg::CFG_W-1:0] max_exp;
		int                          count;
	} setting_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [1:0]                      mode = csmab_pkg::MODE_TICK;
	logic                            channel_idle = 1'b0;
	logic                            packet_offer = 1'b0;
	logic [csmab_pkg::RAND_W-1:0]    random_draw = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            transmit_start;
	logic [1:0]                      station_state;
	logic [csmab_pkg::WINDOW_W-1:0]  window_size;
	logic [csmab_pkg::BACKOFF_W-1:0] backoff_left;
	logic                            packet_waiting;
	logic                            cfg_we = 1'b0;
	logic [csmab_pkg::CFG_IDX_W-1:0] cfg_index = csmab_pkg::REG_IFS_TICKS;
	logic [csmab_pkg::CFG_W-1:0]     cfg_data = '0;

	csma_ca_backoff_station dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.channel_idle   (channel_idle),
		.packet_offer   (packet_offer),
		.random_draw    (random_draw),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.transmit_start (transmit_start),
		.station_state  (station_state),
		.window_size    (window_size),
		.backoff_left   (backoff_left),
		.packet_waiting (packet_waiting),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the station registers and state.
	logic [csmab_pkg::CFG_W-1:0]     sh_ifs_ticks = csmab_pkg::IFS_TICKS_RST;
	logic [csmab_pkg::CFG_W-1:0]     sh_min_exp   = csmab_pkg::MIN_WINDOW_RST;
	logic [csmab_pkg::CFG_W-1:0]     sh_max_exp   = csmab_pkg::MAX_WINDOW_RST;
	station_phase_t                  sh_phase     = ST_IDLE;
	logic [csmab_pkg::IFS_W-1:0]     sh_ifs_left  = '0;
	logic [csmab_pkg::BACKOFF_W-1:0] sh_backoff   = '0;
	logic [csmab_pkg::EXP_W-1:0]     sh_wexp      = csmab_pkg::MIN_WINDOW_RST;
	logic                            sh_pending   = 1'b0;

	station_result_t expected_results[$];
	int              req_accepted = 0;
	int              err_count = 0;
	int              stall_cycles = 0;
	int              send_idle_pct = 10;
	int              recv_idle_pct = 81;
	logic            row_typed = 1'b0;
	station_result_t row_result = '0;

	function automatic logic [csmab_pkg::BACKOFF_W-1:0] masked_draw(
		input logic [csmab_pkg::RAND_W-1:0] rnd);
		logic [csmab_pkg::WINDOW_W-1:0] mask;
		mask = (csmab_pkg::WINDOW_W'(1) << sh_wexp) - csmab_pkg::WINDOW_W'(1);
		return rnd[csmab_pkg::BACKOFF_W-1:0] & mask[csmab_pkg::BACKOFF_W-1:0];
	endfunction

	function automatic station_result_t advance_station(input station_req_t r);
		station_result_t res;
		logic            start;
		start = 1'b0;
		case (r.mode)
			csmab_pkg::MODE_TICK: begin
				if (!sh_pending && r.offer)
					sh_pending = 1'b1;
				if (sh_pending) begin
					case (sh_phase)
						ST_IDLE: begin
							sh_phase    = ST_IFS;
							sh_ifs_left = sh_ifs_ticks;
						end
						ST_IFS: begin
							if (!r.idle)
								sh_ifs_left = sh_ifs_ticks;
							else if (sh_ifs_left > 1)
								sh_ifs_left = sh_ifs_left - csmab_pkg::IFS_W'(1);
							else begin
								sh_ifs_left = '0;
								sh_backoff  = masked_draw(r.rnd);
								sh_phase    = ST_BACKOFF;
							end
						end
						ST_BACKOFF: begin
							if (r.idle) begin
								if (sh_backoff > 1)
									sh_backoff = sh_backoff - csmab_pkg::BACKOFF_W'(1);
								else begin
									sh_backoff = '0;
									sh_phase   = ST_TX;
									start      = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			csmab_pkg::MODE_SUCCESS: begin
				if (sh_phase == ST_TX) begin
					sh_wexp    = sh_min_exp;
					sh_pending = 1'b0;
					sh_phase   = ST_IDLE;
				end
			end
			csmab_pkg::MODE_COLLISION: begin
				if (sh_phase == ST_TX) begin
					if (sh_wexp < sh_max_exp)
						sh_wexp = sh_wexp + csmab_pkg::EXP_W'(1);
					else
						sh_wexp = sh_max_exp;
					sh_backoff = masked_draw(r.rnd);
					sh_phase   = ST_BACKOFF;
				end
			end
			default: ;
		endcase
		res.start   = start;
		res.state   = sh_phase;
		res.window  = csmab_pkg::WINDOW_W'(1) << sh_wexp;
		res.backoff = sh_backoff;
		res.waiting = sh_pending;
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		station_req_t    req;
		station_result_t want;
		station_result_t got;
		if (in_valid && in_ready) begin
			req  = '{csmab_pkg::mode_t'(mode), channel_idle, packet_offer, random_draw};
			want = advance_station(req);
			if (row_typed)
				want = row_result;
			expected_results.push_back(want);
			req_accepted++;
		end
		if (out_valid && out_ready) begin
			got = '{transmit_start, station_state, window_size, backoff_left, packet_waiting};
			if (expected_results.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("tb: unexpected result %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got.start !== want.start || got.state !== want.state ||
					got.window !== want.window || got.backoff !== want.backoff ||
					got.waiting !== want.waiting) begin
					err_count++;
					if (err_count <= 10)
						$display("tb: mismatch expected %p actual %p", want, got);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic drive_request(input station_req_t r, input logic typed,
		input station_result_t res);
		int gap;
		int target;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode         = r.mode;
		channel_idle = r.idle;
		packet_offer = r.offer;
		random_draw  = r.rnd;
		row_typed    = typed;
		row_result   = res;
		in_valid     = 1'b1;
		target       = req_accepted + 1;
		do @(negedge clk); while (req_accepted < target);
	endtask

	task automatic drain_station();
		in_valid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input csmab_pkg::reg_index_t idx,
		input logic [csmab_pkg::CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			csmab_pkg::REG_IFS_TICKS:  sh_ifs_ticks = val;
			csmab_pkg::REG_MIN_WINDOW: sh_min_exp   = val;
			csmab_pkg::REG_MAX_WINDOW: sh_max_exp   = val;
			default: ;
		endcase
	endtask

	function automatic station_req_t make_random_req();
		station_req_t r;
		int           pick;
		pick = $urandom_range(0, 99);
		if (sh_phase == ST_TX)
			r.mode = (pick < 40) ? csmab_pkg::MODE_SUCCESS :
				(pick < 80) ? csmab_pkg::MODE_COLLISION :
				(pick < 90) ? csmab_pkg::MODE_TICK : csmab_pkg::MODE_NONE;
		else
			r.mode = (pick < 85) ? csmab_pkg::MODE_TICK :
				(pick < 92) ? csmab_pkg::MODE_SUCCESS :
				(pick < 97) ? csmab_pkg::MODE_COLLISION : csmab_pkg::MODE_NONE;
		r.idle  = ($urandom_range(0, 99) < 80);
		r.offer = ($urandom_range(0, 99) < 40);
		r.rnd   = csmab_pkg::RAND_W'($urandom());
		// Mostly short backoffs so that large windows still reach transmission.
		if ($urandom_range(0, 99) < 80)
			r.rnd = r.rnd & 16'h8003;
		return r;
	endfunction

	function automatic script_row_t mk(input csmab_pkg::mode_t m, input logic idle,
		input logic offer, input logic [csmab_pkg::RAND_W-1:0] rnd, input logic typed,
		input logic start, input station_phase_t ph,
		input logic [csmab_pkg::WINDOW_W-1:0] win,
		input logic [csmab_pkg::BACKOFF_W-1:0] bo, input logic pw);
		script_row_t row;
		row.req   = '{m, idle, offer, rnd};
		row.typed = typed;
		row.res   = '{start, ph, win, bo, pw};
		return row;
	endfunction

	initial begin : stimulus
		script_row_t script[$];
		setting_t    settings[6];
		int          random_sent;
		int          total_random;

		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b0,
			ST_IDLE, 16'd8, 15'd0, 1'b0));
		script.push_back(mk(csmab_pkg::MODE_SUCCESS, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0,
			ST_IDLE, 16'd8, 15'd0, 1'b0));
		script.push_back(mk(csmab_pkg::MODE_COLLISION, 1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b0,
			ST_IDLE, 16'd8, 15'd0, 1'b0));
		script.push_back(mk(csmab_pkg::MODE_NONE, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0,
			ST_IDLE, 16'd8, 15'd0, 1'b0));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b0,
			ST_IFS, 16'd8, 15'd0, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0,
			ST_IFS, 16'd8, 15'd0, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0,
			ST_IFS, 16'd8, 15'd0, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b0,
			ST_IFS, 16'd8, 15'd0, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b1, 1'b0, 16'hFFFF, 1'b1, 1'b0,
			ST_BACKOFF, 16'd8, 15'd7, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_SUCCESS, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b0,
			ST_BACKOFF, 16'd8, 15'd7, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0,
			ST_BACKOFF, 16'd8, 15'd7, 1'b1));
		repeat (6)
			script.push_back(mk(csmab_pkg::MODE_TICK, 1'b1, 1'($urandom_range(0, 1)),
				csmab_pkg::RAND_W'($urandom()), 1'b0, 1'b0, ST_IDLE, 16'd0, 15'd0, 1'b0));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b1,
			ST_TX, 16'd8, 15'd0, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b0,
			ST_TX, 16'd8, 15'd0, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_NONE, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b0,
			ST_TX, 16'd8, 15'd0, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_COLLISION, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0,
			ST_BACKOFF, 16'd16, 15'd0, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b1,
			ST_TX, 16'd16, 15'd0, 1'b1));
		script.push_back(mk(csmab_pkg::MODE_SUCCESS, 1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b0,
			ST_IDLE, 16'd8, 15'd0, 1'b0));
		script.push_back(mk(csmab_pkg::MODE_TICK, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b0,
			ST_IDLE, 16'd8, 15'd0, 1'b0));

		settings[0] = '{csmab_pkg::IFS_TICKS_RST, csmab_pkg::MIN_WINDOW_RST,
			csmab_pkg::MAX_WINDOW_RST, 300};
		settings[1] = '{4'd0,  4'd0,  4'd0,  250};
		settings[2] = '{4'd15, 4'd15, 4'd15, 80};
		settings[3] = '{4'd1,  4'd5,  4'd2,  300};
		settings[4] = '{4'd2,  4'd0,  4'd15, 250};
		settings[5] = '{4'd1,  4'd2,  4'd4,  220};

		total_random = 0;
		foreach (settings[p])
			total_random += settings[p].count;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[k])
			drive_request(script[k].req, script[k].typed, script[k].res);

		random_sent = 0;
		foreach (settings[p]) begin
			if (p > 0) begin
				drain_station();
				write_reg(csmab_pkg::REG_IFS_TICKS, settings[p].ifs);
				write_reg(csmab_pkg::REG_MIN_WINDOW, settings[p].min_exp);
				write_reg(csmab_pkg::REG_MAX_WINDOW, settings[p].max_exp);
				if (p == 5)
					write_reg(csmab_pkg::REG_UNUSED, 4'hF);
			end
			for (int i = 0; i < settings[p].count; i++) begin
				if (random_sent < total_random / 3) begin
					send_idle_pct = 10;
					recv_idle_pct = 81;
				end else if (random_sent < 2 * total_random / 3) begin
					send_idle_pct = 81;
					recv_idle_pct = 10;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				drive_request(make_random_req(), 1'b0, '0);
				random_sent++;
			end
		end

		drain_station();
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

### filelist.f
rtl/csmab_pkg.sv
rtl/csma_ca_backoff_station.sv
tb/tb.sv
